// File: hdl/llars_pkg.sv
`timescale 1ns / 1ps
package llars_pkg;

  localparam int ROW_BITS = 64;
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 1024;
  localparam int ROW_LIMIT = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] REG_ROWS_IN_USE = 2'd0;
  localparam logic [1:0] REG_COLS_IN_USE = 2'd1;
  localparam logic [1:0] REG_BIRTH_MASK = 2'd2;
  localparam logic [1:0] REG_SURVIVAL_MASK = 2'd3;

  typedef struct packed {
    logic [ROW_BITS-1:0] above;
    logic [ROW_BITS-1:0] mid;
    logic [ROW_BITS-1:0] below;
    logic [ROW_BITS-1:0] first;
    logic [ROW_BITS-1:0] second;
    logic [9:0] row_k;
    logic last;
  } job_t;

  typedef struct packed {
    logic [6:0] cols_in_use;
    logic [8:0] birth_mask;
    logic [8:0] survival_mask;
  } rule_cfg_t;

  typedef enum logic [1:0] {
    PH_MAIN,
    PH_WRAP,
    PH_ZERO
  } phase_t;

  function automatic logic [6:0] eff_cols(input logic [6:0] cols);
    logic [6:0] c;
    c = cols;
    if (c < 7'd3) begin
      c = 7'd3;
    end
    if (c > 7'(MAX_COLS)) begin
      c = 7'(MAX_COLS);
    end
    return c;
  endfunction

  function automatic logic [ROW_BITS-1:0] next_gen(
    input logic [ROW_BITS-1:0] above_in,
    input logic [ROW_BITS-1:0] mid_in,
    input logic [ROW_BITS-1:0] below_in,
    input logic [6:0] cols,
    input logic [8:0] birth,
    input logic [8:0] survive
  );
    logic [ROW_BITS-1:0] m;
    logic [ROW_BITS-1:0] a;
    logic [ROW_BITS-1:0] b;
    logic [ROW_BITS-1:0] d;
    logic [ROW_BITS-1:0] al;
    logic [ROW_BITS-1:0] ar;
    logic [ROW_BITS-1:0] bl;
    logic [ROW_BITS-1:0] br;
    logic [ROW_BITS-1:0] dl;
    logic [ROW_BITS-1:0] dr;
    logic [ROW_BITS-1:0] res;
    logic [5:0] top_idx;
    logic [3:0] n;
    logic [8:0] rule;
    for (int c = 0; c < ROW_BITS; c++) begin
      m[c] = (7'(c) < cols);
    end
    top_idx = 6'(cols - 7'd1);
    a = above_in & m;
    b = mid_in & m;
    d = below_in & m;
    for (int c = 0; c < ROW_BITS; c++) begin
      if (c == 0) begin
        al[c] = a[top_idx];
        bl[c] = b[top_idx];
        dl[c] = d[top_idx];
      end else begin
        al[c] = a[c-1];
        bl[c] = b[c-1];
        dl[c] = d[c-1];
      end
      if (6'(c) == top_idx) begin
        ar[c] = a[0];
        br[c] = b[0];
        dr[c] = d[0];
      end else if (c == ROW_BITS - 1) begin
        ar[c] = 1'b0;
        br[c] = 1'b0;
        dr[c] = 1'b0;
      end else begin
        ar[c] = a[(c+1)%ROW_BITS];
        br[c] = b[(c+1)%ROW_BITS];
        dr[c] = d[(c+1)%ROW_BITS];
      end
    end
    al = al & m;
    bl = bl & m;
    dl = dl & m;
    ar = ar & m;
    br = br & m;
    dr = dr & m;
    for (int c = 0; c < ROW_BITS; c++) begin
      n = 4'(a[c]) + 4'(al[c]) + 4'(ar[c]) + 4'(bl[c]) + 4'(br[c])
        + 4'(d[c]) + 4'(dl[c]) + 4'(dr[c]);
      rule = b[c] ? survive : birth;
      res[c] = rule[n] & m[c];
    end
    return res;
  endfunction

endpackage

// File: hdl/llars_front.sv
`timescale 1ns / 1ps
module llars_front (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  logic [llars_pkg::ROW_BITS-1:0] row_cells,
  input  logic [10:0] rows_in_use,
  output logic push,
  output llars_pkg::job_t job
);

  logic [llars_pkg::ROW_BITS-1:0] first_row;
  logic [llars_pkg::ROW_BITS-1:0] second_row;
  logic [llars_pkg::ROW_BITS-1:0] older_row;
  logic [llars_pkg::ROW_BITS-1:0] newer_row;
  logic [9:0] row_counter;
  logic [9:0] row_counter_next;
  logic [10:0] eff_rows;
  logic last;

  always_comb begin
    eff_rows = rows_in_use;
    if (eff_rows < 11'd3) begin
      eff_rows = 11'd3;
    end
    if (eff_rows > 11'(llars_pkg::ROW_LIMIT)) begin
      eff_rows = 11'(llars_pkg::ROW_LIMIT);
    end
    last = ({1'b0, row_counter} + 11'd1) >= eff_rows;
    push = accept && (row_counter >= 10'd2);
    job.above = older_row;
    job.mid = newer_row;
    job.below = row_cells;
    job.first = first_row;
    job.second = second_row;
    job.row_k = row_counter;
    job.last = last;
    if (row_counter < 10'd2) begin
      row_counter_next = row_counter + 10'd1;
    end else if (last) begin
      row_counter_next = 10'd0;
    end else begin
      row_counter_next = row_counter + 10'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter <= 10'd0;
    end else if (accept) begin
      row_counter <= row_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (row_counter == 10'd0) begin
        first_row <= row_cells;
      end
      if (row_counter == 10'd1) begin
        second_row <= row_cells;
      end
      older_row <= newer_row;
      newer_row <= row_cells;
    end
  end

endmodule

// File: hdl/llars_queue.sv
`timescale 1ns / 1ps
module llars_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  llars_pkg::job_t push_job,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output llars_pkg::job_t head
);

  localparam int PTR_W = (llars_pkg::QUEUE_DEPTH > 1) ? $clog2(llars_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(llars_pkg::QUEUE_DEPTH + 1);

  llars_pkg::job_t entries [llars_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(llars_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(llars_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(llars_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// File: hdl/llars_back.sv
`timescale 1ns / 1ps
module llars_back (
  input  logic clk,
  input  logic rst,
  input  logic head_valid,
  input  llars_pkg::job_t head,
  input  llars_pkg::rule_cfg_t cfg,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output logic [9:0] row_number,
  output logic [llars_pkg::ROW_BITS-1:0] next_cells,
  output logic frame_done
);

  llars_pkg::phase_t phase;
  llars_pkg::phase_t phase_next;
  logic advance;
  logic [llars_pkg::ROW_BITS-1:0] sel_above;
  logic [llars_pkg::ROW_BITS-1:0] sel_mid;
  logic [llars_pkg::ROW_BITS-1:0] sel_below;
  logic [9:0] sel_row;
  logic sel_done;

  assign advance = head_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= llars_pkg::PH_MAIN;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    pop = 1'b0;
    sel_above = head.above;
    sel_mid = head.mid;
    sel_below = head.below;
    sel_row = head.row_k - 10'd1;
    sel_done = 1'b0;
    case (phase)
      llars_pkg::PH_MAIN: begin
        if (advance) begin
          if (head.last) begin
            phase_next = llars_pkg::PH_WRAP;
          end else begin
            pop = 1'b1;
          end
        end
      end
      llars_pkg::PH_WRAP: begin
        sel_above = head.mid;
        sel_mid = head.below;
        sel_below = head.first;
        sel_row = head.row_k;
        if (advance) begin
          phase_next = llars_pkg::PH_ZERO;
        end
      end
      llars_pkg::PH_ZERO: begin
        sel_above = head.below;
        sel_mid = head.first;
        sel_below = head.second;
        sel_row = 10'd0;
        sel_done = 1'b1;
        if (advance) begin
          phase_next = llars_pkg::PH_MAIN;
          pop = 1'b1;
        end
      end
      default: begin
        phase_next = llars_pkg::PH_MAIN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      row_number <= sel_row;
      frame_done <= sel_done;
      next_cells <= llars_pkg::next_gen(sel_above, sel_mid, sel_below,
                                        llars_pkg::eff_cols(cfg.cols_in_use),
                                        cfg.birth_mask, cfg.survival_mask);
    end
  end

endmodule

// File: hdl/life_like_automaton_row_stepper_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  row_cells
// out       output     out_valid/out_stall  row_number, next_cells, frame_done
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One row is taken per cycle unless the queue is full; each row after the second yields
// one result, and the last row of a frame yields three, in the main, wrap and zero phases.
// Results pass through a two-entry job queue and a registered output stage.
// Reset is synchronous and returns the row counter and all handshakes to idle.
// A stall on the output fills the queue, after which the input is stalled.
module life_like_automaton_row_stepper_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [63:0] row_cells,
  output logic out_valid,
  input  logic out_stall,
  output logic [9:0] row_number,
  output logic [63:0] next_cells,
  output logic frame_done,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [10:0] cfg_data
);

  logic [10:0] rows_in_use;
  llars_pkg::rule_cfg_t rule_cfg;
  logic accept;
  logic push;
  logic pop;
  logic full;
  logic not_empty;
  llars_pkg::job_t push_job;
  llars_pkg::job_t head;

  assign cfg_ready = 1'b1;
  assign in_stall = full;
  assign accept = in_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 11'd64;
      rule_cfg.cols_in_use <= 7'd64;
      rule_cfg.birth_mask <= 9'd8;
      rule_cfg.survival_mask <= 9'd12;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        llars_pkg::REG_ROWS_IN_USE: rows_in_use <= cfg_data;
        llars_pkg::REG_COLS_IN_USE: rule_cfg.cols_in_use <= cfg_data[6:0];
        llars_pkg::REG_BIRTH_MASK: rule_cfg.birth_mask <= cfg_data[8:0];
        llars_pkg::REG_SURVIVAL_MASK: rule_cfg.survival_mask <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  llars_front u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .row_cells(row_cells),
    .rows_in_use(rows_in_use),
    .push(push),
    .job(push_job)
  );

  llars_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_job(push_job),
    .pop(pop),
    .full(full),
    .not_empty(not_empty),
    .head(head)
  );

  llars_back u_back (
    .clk(clk),
    .rst(rst),
    .head_valid(not_empty),
    .head(head),
    .cfg(rule_cfg),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .row_number(row_number),
    .next_cells(next_cells),
    .frame_done(frame_done)
  );

endmodule
